@@ rtl/core/utf8_to_codepoint_decoder_unit_defines.svh @@
// Assertion macros used by the UTF-8 decoder top level.
`ifndef UTF8_TO_CODEPOINT_DECODER_UNIT_DEFINES_SVH
`define UTF8_TO_CODEPOINT_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UTFD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define UTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/utfd_pkg.sv @@
// Types, constants and helper functions of the UTF-8 decoder.
`timescale 1ns / 1ps
`default_nettype none
package utfd_pkg;

    localparam int MAX_SEQ_LEN_DEF = 4;
    localparam int VALUE_W         = 21;
    localparam int CP1252_N        = 27;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_BAD_LEAD   = 3'd1;
    localparam logic [2:0] STATUS_BAD_CONT   = 3'd2;
    localparam logic [2:0] STATUS_INCOMPLETE = 3'd3;
    localparam logic [2:0] STATUS_NOT_1252   = 3'd4;

    localparam logic [15:0] CP1252_CODE [CP1252_N] = '{
        16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D, 16'h2018,
        16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h02DC,
        16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178
    };
    localparam logic [7:0] CP1252_BYTE [CP1252_N] = '{
        8'd128, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136, 8'd137,
        8'd138, 8'd139, 8'd140, 8'd142, 8'd145, 8'd146, 8'd147, 8'd148, 8'd149,
        8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd155, 8'd156, 8'd158, 8'd159
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] char_value;
        logic [2:0]         status;
        logic               is_last;
    } t_out_item;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [1:0]         rem;
        logic [VALUE_W-1:0] partial;
        logic               discard;
    } t_dec_state;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } t_map;

    // Count leading one bits of a byte (0 to 8).
    function automatic logic [3:0] lead_ones(input logic [7:0] b);
        logic [3:0] n;
        logic       run;
        n   = 4'd0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            if (run && b[i]) begin
                n = n + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

    // Look up the Windows-1252 byte of a code point above 0xFF.
    function automatic t_map map_1252(input logic [VALUE_W-1:0] cp);
        t_map m;
        m = '0;
        for (int i = 0; i < CP1252_N; i++) begin
            if (cp == {{(VALUE_W-16){1'b0}}, CP1252_CODE[i]}) begin
                m.hit  = 1'b1;
                m.code = CP1252_BYTE[i];
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/utfd_step_logic.sv @@
// Per-byte decode: next state and optional result for one byte.
`timescale 1ns / 1ps
`default_nettype none
module utfd_step_logic #(
    parameter int MAX_SEQ_LEN = utfd_pkg::MAX_SEQ_LEN_DEF
) (
    input  wire utfd_pkg::t_dec_state  i_state,
    input  wire utfd_pkg::t_in_item    i_item,
    input  wire                        i_mode,
    output utfd_pkg::t_dec_state       o_state,
    output logic                       o_emit,
    output utfd_pkg::t_out_item        o_result
);
    import utfd_pkg::*;

    logic [3:0]         lead_n;
    logic [VALUE_W-1:0] cp;
    logic [VALUE_W-1:0] cont_val;
    logic               do_finish;
    logic               do_fail;
    logic [2:0]         fail_code;
    logic               str_end;
    t_map               map;

    assign str_end  = i_item.string_end;
    assign lead_n   = lead_ones(i_item.in_byte);
    assign cont_val = {i_state.partial[VALUE_W-7:0], i_item.in_byte[5:0]};

    always_comb begin
        o_state   = i_state;
        o_emit    = 1'b0;
        o_result  = '0;
        cp        = '0;
        do_finish = 1'b0;
        do_fail   = 1'b0;
        fail_code = STATUS_OK;

        if (i_state.discard) begin
            // drop bytes until the string closes
            if (str_end) begin
                o_state.discard = 1'b0;
            end
        end else if (i_state.rem == 2'd0) begin
            if (lead_n == 4'd0) begin
                do_finish = 1'b1;
                cp        = {{(VALUE_W-8){1'b0}}, i_item.in_byte};
            end else if (lead_n == 4'd1 || lead_n > 4'(MAX_SEQ_LEN)) begin
                do_fail   = 1'b1;
                fail_code = STATUS_BAD_LEAD;
            end else begin
                o_state.partial = {{(VALUE_W-8){1'b0}}, i_item.in_byte & (8'hFF >> lead_n)};
                o_state.rem     = lead_n[1:0] - 2'd1;
                if (str_end) begin
                    do_fail   = 1'b1;
                    fail_code = STATUS_INCOMPLETE;
                end
            end
        end else begin
            if (i_item.in_byte[7:6] != 2'b10) begin
                do_fail   = 1'b1;
                fail_code = STATUS_BAD_CONT;
            end else begin
                o_state.partial = cont_val;
                o_state.rem     = i_state.rem - 2'd1;
                if (i_state.rem == 2'd1) begin
                    do_finish = 1'b1;
                    cp        = cont_val;
                end else if (str_end) begin
                    do_fail   = 1'b1;
                    fail_code = STATUS_INCOMPLETE;
                end
            end
        end

        map = map_1252(cp);

        if (do_finish) begin
            o_state.rem     = 2'd0;
            o_state.partial = '0;
            if (!i_mode || cp[VALUE_W-1:8] == '0) begin
                o_emit              = 1'b1;
                o_result.char_value = cp;
                o_result.status     = STATUS_OK;
                o_result.is_last    = str_end;
            end else if (map.hit) begin
                o_emit              = 1'b1;
                o_result.char_value = {{(VALUE_W-8){1'b0}}, map.code};
                o_result.status     = STATUS_OK;
                o_result.is_last    = str_end;
            end else begin
                do_fail   = 1'b1;
                fail_code = STATUS_NOT_1252;
            end
        end

        if (do_fail) begin
            o_state.rem         = 2'd0;
            o_state.partial     = '0;
            o_state.discard     = !str_end;
            o_emit              = 1'b1;
            o_result.char_value = '0;
            o_result.status     = fail_code;
            o_result.is_last    = 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/utf8_to_codepoint_decoder_unit.sv @@
// UTF-8 decoder top level: takes one byte per transaction and returns decoded
// characters. A byte is registered on acceptance, decoded combinationally
// against the running sequence state, and any character or error is registered
// in the output register when the byte moves on. One byte is taken every cycle
// as long as the output side does not stall; the output register is the only
// place a result waits, and a byte that yields no result (lead or middle byte
// of a sequence, dropped byte after an error) moves on even while a result is
// held. output_mode selects code points (0) or Windows-1252 bytes (1); the user
// must write it only while the block is idle, and the block itself does not
// enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_codepoint_decoder_unit_defines.svh"
module utf8_to_codepoint_decoder_unit #(
    parameter int MAX_SEQ_LEN = utfd_pkg::MAX_SEQ_LEN_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_wr_en,
    input  wire                     i_cfg_wr_data,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire utfd_pkg::t_in_item i_in_item,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output utfd_pkg::t_out_item     o_out_item
);
    import utfd_pkg::*;

    logic       r_mode;
    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    t_dec_state r_state;

    t_dec_state n_state;
    t_out_item  n_out;
    logic       step_emit;
    logic       out_free;
    logic       advance;
    logic       in_take;

    utfd_step_logic #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN)
    ) u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .i_mode   (r_mode),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (n_out)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    // a byte with no result never waits on the output register
    assign advance    = r_in_valid && (!step_emit || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && step_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
        if (advance && step_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `UTFD_ASSERT_SAME(a_err_is_last, i_clk, i_rst_n,
        o_out_valid && o_out_item.status != STATUS_OK, o_out_item.is_last,
        "error result without is_last")
    `UTFD_ASSERT_SAME(a_err_zero_value, i_clk, i_rst_n,
        o_out_valid && o_out_item.status != STATUS_OK, o_out_item.char_value == '0,
        "error result with nonzero value")
    `UTFD_ASSERT_SAME(a_open_seq_not_discard, i_clk, i_rst_n,
        r_state.rem != 2'd0, !r_state.discard,
        "open sequence while dropping bytes")
    `UTFD_ASSERT_NEXT(a_discard_silent, i_clk, i_rst_n,
        r_in_valid && r_state.discard && !o_in_stall && !(o_out_valid && i_out_stall),
        !($past(step_emit)),
        "result produced while dropping bytes")

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the UTF-8 to code point decoder unit.
`timescale 1ns / 1ps
module tb_top;
    import utfd_pkg::*;

    localparam int LONGEST_SEQ = MAX_SEQ_LEN_DEF;
    localparam int RANDOM_BYTES = 1050;
    localparam int MODE_SWITCH_EVERY = 200;
    localparam int DRAIN_CYCLES = 6;

    // Windows-1252 bytes 0x80..0x9F and the code points they stand for.
    localparam logic [15:0] WIN1252_CP [27] = '{
        16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D, 16'h2018,
        16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h02DC,
        16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178
    };
    localparam logic [7:0] WIN1252_BYTE [27] = '{
        8'h80, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
        8'h8A, 8'h8B, 8'h8C, 8'h8E, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95,
        8'h96, 8'h97, 8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9E, 8'h9F
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       str_end;
        logic       mode;
        logic       fixed;
        logic       has_char;
        t_out_item  want;
    } t_byte_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_wr_en = 1'b0;
    logic      i_cfg_wr_data = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // Decoder shadow state
    logic [1:0]  cont_left = 2'd0;
    logic [20:0] acc_cp = 21'd0;
    bit          dropping = 1'b0;
    bit          mode_1252 = 1'b0;

    t_out_item  pending_chars [$];
    t_byte_row  directed_rows [$];
    t_in_item   string_bytes [$];
    int         mismatch_count = 0;
    int         out_hold = 0;
    bit         send_calm = 1'b0;
    bit         recv_calm = 1'b0;

    utf8_to_codepoint_decoder_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pick_wait(input bit calm);
        if (calm) begin
            return 0;
        end
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 14);
        end
        return $urandom_range(0, 2);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic bit flag_error(input logic [2:0] st, input logic str_end,
                                      output t_out_item r);
        cont_left = 2'd0;
        acc_cp    = 21'd0;
        dropping  = !str_end;
        r         = '0;
        r.status  = st;
        r.is_last = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit finish_char(input logic [20:0] cp, input logic str_end,
                                       output t_out_item r);
        cont_left = 2'd0;
        acc_cp    = 21'd0;
        r         = '0;
        r.status  = STATUS_OK;
        r.is_last = str_end;
        if (!mode_1252 || cp < 21'h100) begin
            r.char_value = cp;
            return 1'b1;
        end
        for (int i = 0; i < 27; i++) begin
            if (cp == {5'd0, WIN1252_CP[i]}) begin
                r.char_value = {13'd0, WIN1252_BYTE[i]};
                return 1'b1;
            end
        end
        return flag_error(STATUS_NOT_1252, str_end, r);
    endfunction

    // Advance the shadow decoder by one byte; return 1 when a result (character or error) is due.
    function automatic bit decode_byte(input logic [7:0] b, input logic str_end,
                                       output t_out_item r);
        int ones;
        r = '0;
        if (dropping) begin
            if (str_end) begin
                dropping = 1'b0;
            end
            return 1'b0;
        end
        if (cont_left == 2'd0) begin
            ones = 0;
            while (ones < 8 && b[7 - ones] == 1'b1) begin
                ones++;
            end
            if (ones == 0) begin
                return finish_char({13'd0, b}, str_end, r);
            end
            if (ones == 1 || ones > LONGEST_SEQ) begin
                return flag_error(STATUS_BAD_LEAD, str_end, r);
            end
            acc_cp    = {13'd0, b & (8'hFF >> ones)};
            cont_left = 2'(ones - 1);
            if (str_end) begin
                return flag_error(STATUS_INCOMPLETE, str_end, r);
            end
            return 1'b0;
        end
        if (b[7:6] != 2'b10) begin
            return flag_error(STATUS_BAD_CONT, str_end, r);
        end
        acc_cp    = {acc_cp[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
            return finish_char(acc_cp, str_end, r);
        end
        if (str_end) begin
            return flag_error(STATUS_INCOMPLETE, str_end, r);
        end
        return 1'b0;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic push_byte(input t_in_item it, input bit fixed, input bit has_char,
                             input t_out_item want);
        int gap;
        t_out_item got;
        bit due;
        gap = pick_wait(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        due = decode_byte(it.in_byte, it.string_end, got);
        if (fixed) begin
            if (has_char) begin
                pending_chars.push_back(want);
            end
        end else if (due) begin
            pending_chars.push_back(got);
        end
        @(negedge i_clk);
    endtask

    // Drain the block, then write output_mode.
    task automatic set_mode(input bit m);
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        mode_1252 = m;
    endtask

    task automatic add_row(input logic [7:0] b, input logic str_end, input logic m,
                           input logic fixed, input logic has_char,
                           input logic [20:0] v, input logic [2:0] st,
                           input logic is_last);
        t_byte_row row;
        row.in_byte         = b;
        row.str_end         = str_end;
        row.mode            = m;
        row.fixed           = fixed;
        row.has_char        = has_char;
        row.want.char_value = v;
        row.want.status     = st;
        row.want.is_last    = is_last;
        directed_rows.push_back(row);
    endtask

    // Append the first keep bytes of a len-byte encoding of cp.
    task automatic put_seq(input int len, input logic [20:0] cp, input int keep);
        logic [7:0] s [4];
        t_in_item it;
        s = '{8'h00, 8'h00, 8'h00, 8'h00};
        case (len)
            1: begin
                s[0] = {1'b0, cp[6:0]};
            end
            2: begin
                s[0] = {3'b110, cp[10:6]};
                s[1] = {2'b10, cp[5:0]};
            end
            3: begin
                s[0] = {4'b1110, cp[15:12]};
                s[1] = {2'b10, cp[11:6]};
                s[2] = {2'b10, cp[5:0]};
            end
            default: begin
                s[0] = {5'b11110, cp[20:18]};
                s[1] = {2'b10, cp[17:12]};
                s[2] = {2'b10, cp[11:6]};
                s[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++) begin
            it.in_byte    = s[i];
            it.string_end = 1'b0;
            string_bytes.push_back(it);
        end
    endtask

    // Mostly well-formed strings with random content, some broken, a little noise.
    task automatic build_string();
        int nchars;
        int kind;
        int len;
        logic [20:0] cp;
        logic [7:0] x;
        t_in_item it;
        string_bytes.delete();
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                it.in_byte    = 8'($urandom);
                it.string_end = 1'($urandom);
                string_bytes.push_back(it);
            end
            return;
        end
        nchars = $urandom_range(1, 6);
        for (int c = 0; c < nchars; c++) begin
            kind = $urandom_range(0, 19);
            len  = $urandom_range(1, 4);
            cp   = 21'($urandom);
            if (kind < 10) begin
                put_seq(len, cp, len);
            end else if (kind < 14) begin
                cp = {5'd0, WIN1252_CP[$urandom_range(0, 26)]};
                put_seq(cp < 21'h800 ? 2 : 3, cp, cp < 21'h800 ? 2 : 3);
            end else if (kind < 16) begin
                cp = 21'($urandom_range(8'h80, 8'hFF));
                put_seq(2, cp, 2);
            end else if (kind == 16) begin
                it.in_byte = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                  : 8'($urandom_range(8'hF8, 8'hFF));
                it.string_end = 1'b0;
                string_bytes.push_back(it);
            end else if (kind == 17) begin
                len = $urandom_range(2, 4);
                put_seq(len, cp, $urandom_range(1, len - 1));
                x = 8'($urandom);
                if (x[7:6] == 2'b10) begin
                    x[6] = 1'b1;
                end
                it.in_byte    = x;
                it.string_end = 1'b0;
                string_bytes.push_back(it);
            end else begin
                // truncated sequence closes the string
                len = $urandom_range(2, 4);
                put_seq(len, cp, $urandom_range(1, len - 1));
                break;
            end
        end
        it = string_bytes.pop_back();
        it.string_end = 1'b1;
        string_bytes.push_back(it);
    endtask

    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold = out_hold - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction %h", o_out_item));
            end else begin
                want = pending_chars.pop_front();
                if (o_out_item.char_value !== want.char_value) begin
                    report_mismatch($sformatf("char_value %h, want %h",
                                              o_out_item.char_value, want.char_value));
                end
                if (o_out_item.status !== want.status) begin
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_out_item.status, want.status));
                end
                if (o_out_item.is_last !== want.is_last) begin
                    report_mismatch($sformatf("is_last %b, want %b",
                                              o_out_item.is_last, want.is_last));
                end
            end
            out_hold = pick_wait(recv_calm);
        end
    end

    initial begin
        t_in_item it;
        t_byte_row row;
        int sent;
        int next_switch;
        int waited;

        // Mode 0 first, relying on the reset value of output_mode.
        add_row(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 21'h00, STATUS_OK, 1'b0);
        add_row(8'h7F, 1'b1, 1'b0, 1'b1, 1'b1, 21'h7F, STATUS_OK, 1'b1);
        add_row(8'h80, 1'b0, 1'b0, 1'b1, 1'b1, 21'h0, STATUS_BAD_LEAD, 1'b1);
        add_row(8'h41, 1'b1, 1'b0, 1'b1, 1'b0, 21'h0, STATUS_OK, 1'b0);
        add_row(8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 21'h0, STATUS_BAD_LEAD, 1'b1);
        add_row(8'hF8, 1'b1, 1'b0, 1'b1, 1'b1, 21'h0, STATUS_BAD_LEAD, 1'b1);
        add_row(8'hC3, 1'b0, 1'b0, 1'b1, 1'b0, 21'h0, STATUS_OK, 1'b0);
        add_row(8'hA9, 1'b1, 1'b0, 1'b1, 1'b1, 21'hE9, STATUS_OK, 1'b1);
        add_row(8'hF7, 1'b0, 1'b0, 1'b0, 1'b0, 21'h0, STATUS_OK, 1'b0);
        add_row(8'hBF, 1'b0, 1'b0, 1'b0, 1'b0, 21'h0, STATUS_OK, 1'b0);
        add_row(8'hBF, 1'b0, 1'b0, 1'b0, 1'b0, 21'h0, STATUS_OK, 1'b0);
        add_row(8'hBF, 1'b1, 1'b0, 1'b0, 1'b0, 21'h0, STATUS_OK, 1'b0);
        // bad continuation on the closing byte: no drop phase after it
        add_row(8'hE2, 1'b0, 1'b0, 1'b0, 1'b0, 21'h0, STATUS_OK, 1'b0);
        add_row(8'h41, 1'b1, 1'b0, 1'b1, 1'b1, 21'h0, STATUS_BAD_CONT, 1'b1);
        add_row(8'hE2, 1'b0, 1'b0, 1'b0, 1'b0, 21'h0, STATUS_OK, 1'b0);
        add_row(8'hC0, 1'b0, 1'b0, 1'b1, 1'b1, 21'h0, STATUS_BAD_CONT, 1'b1);
        add_row(8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 21'h0, STATUS_OK, 1'b0);
        add_row(8'hE2, 1'b0, 1'b0, 1'b0, 1'b0, 21'h0, STATUS_OK, 1'b0);
        add_row(8'h82, 1'b1, 1'b0, 1'b1, 1'b1, 21'h0, STATUS_INCOMPLETE, 1'b1);
        add_row(8'hC0, 1'b1, 1'b0, 1'b1, 1'b1, 21'h0, STATUS_INCOMPLETE, 1'b1);
        add_row(8'hE2, 1'b0, 1'b1, 1'b0, 1'b0, 21'h0, STATUS_OK, 1'b0);
        add_row(8'h82, 1'b0, 1'b1, 1'b0, 1'b0, 21'h0, STATUS_OK, 1'b0);
        add_row(8'hAC, 1'b0, 1'b1, 1'b1, 1'b1, 21'h80, STATUS_OK, 1'b0);
        add_row(8'hC4, 1'b0, 1'b1, 1'b0, 1'b0, 21'h0, STATUS_OK, 1'b0);
        add_row(8'h80, 1'b0, 1'b1, 1'b1, 1'b1, 21'h0, STATUS_NOT_1252, 1'b1);
        add_row(8'h41, 1'b1, 1'b1, 1'b1, 1'b0, 21'h0, STATUS_OK, 1'b0);
        add_row(8'hC3, 1'b0, 1'b1, 1'b0, 1'b0, 21'h0, STATUS_OK, 1'b0);
        add_row(8'hBF, 1'b1, 1'b1, 1'b0, 1'b0, 21'h0, STATUS_OK, 1'b0);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.mode != mode_1252) begin
                set_mode(row.mode);
            end
            it.in_byte    = row.in_byte;
            it.string_end = row.str_end;
            push_byte(it, row.fixed, row.has_char, row.want);
        end

        sent        = 0;
        next_switch = MODE_SWITCH_EVERY;
        while (sent < RANDOM_BYTES) begin
            if (sent >= next_switch) begin
                set_mode(!mode_1252);
                next_switch += MODE_SWITCH_EVERY;
            end
            if ($urandom_range(0, 7) == 0) begin
                send_calm = !send_calm;
            end
            if ($urandom_range(0, 7) == 0) begin
                recv_calm = !recv_calm;
            end
            build_string();
            foreach (string_bytes[k]) begin
                push_byte(string_bytes[k], 1'b0, 1'b0, '0);
            end
            sent += string_bytes.size();
        end

        i_in_valid <= 1'b0;
        for (waited = 0; pending_chars.size() != 0 && waited < 2000; waited++) begin
            @(negedge i_clk);
        end
        if (pending_chars.size() != 0) begin
            report_mismatch($sformatf("%0d characters never arrived",
                                      pending_chars.size()));
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
